// ===== src/scfp_pkg.sv =====
// Package for the SPI command frame parser.
// Holds the shared constants, error codes and structs; depends on nothing.
`timescale 1ns / 1ps

package scfp_pkg;

  localparam int unsigned NumEntries = 4;
  localparam int unsigned EntryWidth = 13;
  localparam int unsigned IndexWidth = 2;
  localparam logic [3:0]  MaxParams  = 4'd8;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_UNKNOWN_CMD = 3'd1,
    ERR_MISPLACED   = 3'd2,
    ERR_TOO_MANY    = 3'd3,
    ERR_OVERRUN     = 3'd4,
    ERR_ZERO_PARAM  = 3'd5,
    ERR_DROPPED     = 3'd6
  } err_e;

  typedef struct packed {
    logic                  hit;
    logic [IndexWidth-1:0] hit_idx;
    logic [3:0]            active_count;
  } match_t;

  typedef struct packed {
    logic [1:0]  matched_entry;
    logic        frame_begin;
    logic        param_begin;
    logic [3:0]  param_number;
    logic [15:0] param_size;
    logic [15:0] byte_offset;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        param_finish;
    logic        frame_finish;
    logic [15:0] body_length;
    err_e        error_code;
  } result_t;

endpackage

// ===== src/scfp_cmd_table.sv =====
// Command table registers and the parallel command code match.
// Depends on scfp_pkg.
`timescale 1ns / 1ps

module scfp_cmd_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [scfp_pkg::IndexWidth-1:0] cfg_index_i,
  input  logic [scfp_pkg::EntryWidth-1:0] cfg_data_i,
  input  logic [7:0]                     rx_byte_i,
  input  logic [scfp_pkg::IndexWidth-1:0] active_entry_i,
  output scfp_pkg::match_t               match_o
);
  import scfp_pkg::*;

  logic [EntryWidth-1:0] entry_q [NumEntries];
  logic [NumEntries-1:0] code_eq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumEntries; i++) begin
        entry_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      entry_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int i = 0; i < NumEntries; i++) begin
      code_eq[i] = entry_q[i][12] && (entry_q[i][11:4] == rx_byte_i);
    end
  end

  // The lowest-numbered matching entry wins.
  always_comb begin
    match_o.hit = |code_eq;
    match_o.hit_idx = '0;
    for (int i = NumEntries - 1; i >= 0; i--) begin
      if (code_eq[i]) begin
        match_o.hit_idx = IndexWidth'(i);
      end
    end
    match_o.active_count = entry_q[active_entry_i][3:0];
  end

endmodule

// ===== src/scfp_parser.sv =====
// Frame parse state and the single-pass step logic for one received byte.
// Depends on scfp_pkg; the command match comes from scfp_cmd_table.
`timescale 1ns / 1ps

module scfp_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  logic [7:0]                      rx_byte_i,
  input  logic                            transfer_start_i,
  input  scfp_pkg::match_t                match_i,
  output logic [scfp_pkg::IndexWidth-1:0] active_entry_o,
  output scfp_pkg::result_t               res_o
);
  import scfp_pkg::*;

  logic        in_body_q, in_body_d;
  logic [1:0]  tpos_q, tpos_d;
  logic        drop_q, drop_d;
  logic [1:0]  active_q, active_d;
  logic [15:0] flen_q, flen_d;
  logic [15:0] bpos_q, bpos_d;
  logic [16:0] brem_q, brem_d;
  logic        in_param_q, in_param_d;
  logic [3:0]  pcd_q, pcd_d;
  logic [15:0] plen_q, plen_d;
  logic        lbp_q, lbp_d;
  logic [15:0] ppos_q, ppos_d;

  logic [1:0]  pos;
  logic        drop;
  logic [15:0] flen_new;
  logic [15:0] plen_new;
  logic [16:0] need;
  logic        clear;
  err_e        err;

  always_comb begin
    in_body_d  = in_body_q;
    drop       = drop_q && !transfer_start_i;
    pos        = transfer_start_i ? 2'd0 : tpos_q;
    tpos_d     = (pos == 2'd3) ? 2'd3 : pos + 2'd1;
    drop_d     = drop;
    active_d   = active_q;
    flen_d     = flen_q;
    bpos_d     = bpos_q;
    brem_d     = brem_q;
    in_param_d = in_param_q;
    pcd_d      = pcd_q;
    plen_d     = plen_q;
    lbp_d      = lbp_q;
    ppos_d     = ppos_q;
    clear      = 1'b0;
    err        = ERR_NONE;
    flen_new   = flen_q | ((pos == 2'd1) ? {rx_byte_i, 8'h00} : {8'h00, rx_byte_i});
    plen_new   = plen_q | {8'h00, rx_byte_i};
    need       = {1'b0, plen_new} + 17'd2;
    res_o      = '0;

    if (drop) begin
      err = ERR_DROPPED;
    end else if (!in_body_q) begin
      if (pos == 2'd0) begin
        if (match_i.hit) begin
          active_d = match_i.hit_idx;
        end else begin
          err = ERR_UNKNOWN_CMD;
        end
        flen_d = '0;
      end else if (pos != 2'd3) begin
        flen_d = flen_new;
        res_o.body_length = flen_new;
        if (pos == 2'd2) begin
          if (flen_new == 16'd0) begin
            res_o.frame_finish = 1'b1;
            clear = 1'b1;
          end else begin
            in_body_d  = 1'b1;
            bpos_d     = '0;
            brem_d     = {1'b0, flen_new};
            in_param_d = 1'b0;
            plen_d     = '0;
            lbp_d      = 1'b0;
            ppos_d     = '0;
          end
        end
      end else begin
        err = ERR_MISPLACED;
      end
    end else begin
      if (pcd_q >= match_i.active_count) begin
        err = ERR_TOO_MANY;
      end else if (!in_param_q) begin
        if (!lbp_q) begin
          plen_d = {rx_byte_i, 8'h00};
          lbp_d  = 1'b1;
        end else begin
          plen_d     = plen_new;
          lbp_d      = 1'b0;
          in_param_d = 1'b1;
          ppos_d     = '0;
          if (plen_new == 16'd0) begin
            err = ERR_ZERO_PARAM;
          end else if (need > brem_q) begin
            err = ERR_OVERRUN;
          end else begin
            brem_d = brem_q - need;
          end
        end
      end else if (pcd_q >= MaxParams) begin
        err = ERR_TOO_MANY;
      end else begin
        res_o.payload_valid = 1'b1;
        res_o.param_begin   = (ppos_q == 16'd0);
        res_o.param_number  = pcd_q;
        res_o.param_size    = plen_q;
        res_o.byte_offset   = ppos_q;
        res_o.payload_byte  = rx_byte_i;
        if ({1'b0, ppos_q} + 17'd1 == {1'b0, plen_q}) begin
          res_o.param_finish = 1'b1;
          pcd_d      = pcd_q + 4'd1;
          in_param_d = 1'b0;
          ppos_d     = '0;
          plen_d     = '0;
          lbp_d      = 1'b0;
        end else begin
          ppos_d = ppos_q + 16'd1;
        end
      end
      if (err == ERR_NONE) begin
        res_o.frame_begin = (bpos_q == 16'd0);
        res_o.body_length = flen_q;
        if ({1'b0, bpos_q} + 17'd1 == {1'b0, flen_q}) begin
          res_o.frame_finish = 1'b1;
          clear = 1'b1;
        end else begin
          bpos_d = bpos_q + 16'd1;
        end
      end
    end

    if (err != ERR_NONE && err != ERR_DROPPED) begin
      clear  = 1'b1;
      drop_d = 1'b1;
    end
    if (err != ERR_NONE) begin
      res_o = '0;
    end
    if (clear) begin
      in_body_d  = 1'b0;
      flen_d     = '0;
      bpos_d     = '0;
      brem_d     = '0;
      in_param_d = 1'b0;
      pcd_d      = '0;
      plen_d     = '0;
      lbp_d      = 1'b0;
      ppos_d     = '0;
    end
    res_o.matched_entry = active_d;
    res_o.error_code    = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q  <= 1'b0;
      tpos_q     <= '0;
      drop_q     <= 1'b0;
      active_q   <= '0;
      flen_q     <= '0;
      bpos_q     <= '0;
      brem_q     <= '0;
      in_param_q <= 1'b0;
      pcd_q      <= '0;
      plen_q     <= '0;
      lbp_q      <= 1'b0;
      ppos_q     <= '0;
    end else if (advance_i) begin
      in_body_q  <= in_body_d;
      tpos_q     <= tpos_d;
      drop_q     <= drop_d;
      active_q   <= active_d;
      flen_q     <= flen_d;
      bpos_q     <= bpos_d;
      brem_q     <= brem_d;
      in_param_q <= in_param_d;
      pcd_q      <= pcd_d;
      plen_q     <= plen_d;
      lbp_q      <= lbp_d;
      ppos_q     <= ppos_d;
    end
  end

  assign active_entry_o = active_q;

endmodule

// ===== src/spi_command_frame_parser.sv =====
// SPI command frame parser: one result item for every received byte item.
// A byte is first held in the input register; its result is then registered in the result register.
// Throughput: one item per cycle, held up only while the result register is full and stalled.
// Reset clears the command table, the parse state and both pipeline valid bits; no clearing pass.
// Depends on scfp_pkg, scfp_cmd_table and scfp_parser.
`timescale 1ns / 1ps

module spi_command_frame_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [scfp_pkg::IndexWidth-1:0] cfg_index_i,
  input  logic [scfp_pkg::EntryWidth-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      rx_byte_i,
  input  logic                            transfer_start_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      matched_entry_o,
  output logic                            frame_begin_o,
  output logic                            param_begin_o,
  output logic [3:0]                      param_number_o,
  output logic [15:0]                     param_size_o,
  output logic [15:0]                     byte_offset_o,
  output logic [7:0]                      payload_byte_o,
  output logic                            payload_valid_o,
  output logic                            param_finish_o,
  output logic                            frame_finish_o,
  output logic [15:0]                     body_length_o,
  output logic [2:0]                      error_code_o
);
  import scfp_pkg::*;

  logic                  in_valid_q, in_valid_d;
  logic [7:0]            rx_byte_q;
  logic                  start_q;
  logic                  out_valid_q, out_valid_d;
  result_t               res_q;
  result_t               res_d;
  match_t                match;
  logic [IndexWidth-1:0] active_entry;
  logic                  advance;
  logic                  in_load;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_load    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_load) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      rx_byte_q <= rx_byte_i;
      start_q   <= transfer_start_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  scfp_cmd_table u_cmd_table (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .rx_byte_i      (rx_byte_q),
    .active_entry_i (active_entry),
    .match_o        (match)
  );

  scfp_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .rx_byte_i        (rx_byte_q),
    .transfer_start_i (start_q),
    .match_i          (match),
    .active_entry_o   (active_entry),
    .res_o            (res_d)
  );

  assign out_valid_o     = out_valid_q;
  assign matched_entry_o = res_q.matched_entry;
  assign frame_begin_o   = res_q.frame_begin;
  assign param_begin_o   = res_q.param_begin;
  assign param_number_o  = res_q.param_number;
  assign param_size_o    = res_q.param_size;
  assign byte_offset_o   = res_q.byte_offset;
  assign payload_byte_o  = res_q.payload_byte;
  assign payload_valid_o = res_q.payload_valid;
  assign param_finish_o  = res_q.param_finish;
  assign frame_finish_o  = res_q.frame_finish;
  assign body_length_o   = res_q.body_length;
  assign error_code_o    = res_q.error_code;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("Input stalled while the pipeline could move.");

  a_error_clears_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_code_o != ERR_NONE) |->
      (!payload_valid_o && !frame_begin_o && !frame_finish_o && body_length_o == 16'd0))
    else $error("Result with an error carries frame or parameter events.");

  a_param_events_need_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (param_begin_o || param_finish_o)) |-> payload_valid_o)
    else $error("Parameter event on a byte that is not parameter data.");

  a_param_number_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_valid_o) |-> (param_number_o < MaxParams))
    else $error("Parameter data handed out beyond the parameter limit.");

endmodule

// ===== bench/tb.sv =====
// Testbench for spi_command_frame_parser: a scoreboard class predicts one result per byte.
// Directed frames, then random frames and noise; both sides idle at random before phase 4.
// Depends on scfp_pkg and the spi_command_frame_parser RTL.
`timescale 1ns / 1ps

module tb;
  import scfp_pkg::*;

  class frame_parse_board;
    logic [EntryWidth-1:0] entry [NumEntries];
    bit                    in_body;
    logic [1:0]            xfer_pos;
    bit                    drop;
    logic [1:0]            active;
    logic [15:0]           frame_len;
    logic [15:0]           body_pos;
    logic [16:0]           body_rem;
    bit                    in_data;
    logic [3:0]            params_done;
    logic [15:0]           plen;
    bit                    len_hi_seen;
    logic [15:0]           ppos;
    result_t               expected_results[$];
    int unsigned           mismatches;

    function new();
      foreach (entry[i]) entry[i] = '0;
      clear_frame();
      xfer_pos = '0;
      drop = 0;
      active = '0;
      mismatches = 0;
    endfunction

    function void clear_frame();
      in_body = 0;
      frame_len = '0;
      body_pos = '0;
      body_rem = '0;
      in_data = 0;
      params_done = '0;
      plen = '0;
      len_hi_seen = 0;
      ppos = '0;
    endfunction

    function void set_entry(int unsigned idx, logic [EntryWidth-1:0] val);
      entry[idx] = val;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void note_byte(logic [7:0] b, logic start);
      result_t     r;
      logic [1:0]  pos;
      err_e        err;
      logic        first;
      int          hit;
      logic [16:0] need;
      logic [3:0]  cnt;
      r = '0;
      err = ERR_NONE;
      if (start) begin
        xfer_pos = '0;
        drop = 0;
      end
      pos = xfer_pos;
      if (xfer_pos != 2'd3) xfer_pos = xfer_pos + 2'd1;

      if (drop) begin
        err = ERR_DROPPED;
      end else if (!in_body) begin
        if (pos == 2'd0) begin
          hit = -1;
          for (int i = 0; i < NumEntries; i++) begin
            if (hit < 0 && entry[i][12] && entry[i][11:4] == b) hit = i;
          end
          if (hit >= 0) active = hit[1:0];
          else err = ERR_UNKNOWN_CMD;
          frame_len = '0;
        end else if (pos <= 2'd2) begin
          frame_len = frame_len | ((pos == 2'd1) ? {b, 8'h00} : {8'h00, b});
          r.body_length = frame_len;
          if (pos == 2'd2) begin
            if (frame_len == 16'd0) begin
              r.frame_finish = 1'b1;
              clear_frame();
            end else begin
              in_body = 1;
              body_pos = '0;
              body_rem = {1'b0, frame_len};
              in_data = 0;
              plen = '0;
              len_hi_seen = 0;
              ppos = '0;
            end
          end
        end else begin
          err = ERR_MISPLACED;
        end
      end else begin
        cnt = entry[active][3:0];
        first = (body_pos == 16'd0);
        if (params_done >= cnt) begin
          err = ERR_TOO_MANY;
        end else if (!in_data) begin
          if (!len_hi_seen) begin
            plen = {b, 8'h00};
            len_hi_seen = 1;
          end else begin
            plen = plen | {8'h00, b};
            len_hi_seen = 0;
            in_data = 1;
            ppos = '0;
            need = {1'b0, plen} + 17'd2;
            if (plen == 16'd0) err = ERR_ZERO_PARAM;
            else if (need > body_rem) err = ERR_OVERRUN;
            else body_rem = body_rem - need;
          end
        end else if (params_done >= MaxParams) begin
          err = ERR_TOO_MANY;
        end else begin
          r.payload_valid = 1'b1;
          r.param_begin = (ppos == 16'd0);
          r.param_number = params_done;
          r.param_size = plen;
          r.byte_offset = ppos;
          r.payload_byte = b;
          if ({1'b0, ppos} + 17'd1 == {1'b0, plen}) begin
            r.param_finish = 1'b1;
            params_done = params_done + 4'd1;
            in_data = 0;
            ppos = '0;
            plen = '0;
            len_hi_seen = 0;
          end else begin
            ppos = ppos + 16'd1;
          end
        end
        if (err == ERR_NONE) begin
          r.frame_begin = first;
          r.body_length = frame_len;
          if ({1'b0, body_pos} + 17'd1 == {1'b0, frame_len}) begin
            r.frame_finish = 1'b1;
            clear_frame();
          end else begin
            body_pos = body_pos + 16'd1;
          end
        end
      end

      if (err != ERR_NONE && err != ERR_DROPPED) begin
        clear_frame();
        drop = 1;
      end
      if (err != ERR_NONE) r = '0;
      r.matched_entry = active;
      r.error_code = err;
      expected_results.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result item expected none got error_code %0d", $time, got.error_code);
        return;
      end
      want = expected_results.pop_front();
      check_field("matched_entry", want.matched_entry, got.matched_entry);
      check_field("frame_begin", want.frame_begin, got.frame_begin);
      check_field("param_begin", want.param_begin, got.param_begin);
      check_field("param_number", want.param_number, got.param_number);
      check_field("param_size", want.param_size, got.param_size);
      check_field("byte_offset", want.byte_offset, got.byte_offset);
      check_field("payload_byte", want.payload_byte, got.payload_byte);
      check_field("payload_valid", want.payload_valid, got.payload_valid);
      check_field("param_finish", want.param_finish, got.param_finish);
      check_field("frame_finish", want.frame_finish, got.frame_finish);
      check_field("body_length", want.body_length, got.body_length);
      check_field("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned ItemsPerPhase = 142;
  localparam int unsigned DrainCycles   = 6;
  localparam int unsigned HoldCycles    = 150;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [IndexWidth-1:0] cfg_index_i;
  logic [EntryWidth-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            rx_byte_i;
  logic                  transfer_start_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [1:0]            matched_entry_o;
  logic                  frame_begin_o;
  logic                  param_begin_o;
  logic [3:0]            param_number_o;
  logic [15:0]           param_size_o;
  logic [15:0]           byte_offset_o;
  logic [7:0]            payload_byte_o;
  logic                  payload_valid_o;
  logic                  param_finish_o;
  logic                  frame_finish_o;
  logic [15:0]           body_length_o;
  logic [2:0]            error_code_o;

  frame_parse_board      board;
  logic [EntryWidth-1:0] cmd_words [NumEntries];
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_stall_pct = 0;
  int unsigned           hold_req = 0;
  int unsigned           bytes_sent = 0;
  int unsigned           cycles = 0;

  // Directed bytes as {transfer_start, rx_byte}.
  localparam logic [8:0] DirectedBytes [23] = '{
    9'h133,
    9'h1FF, 9'h000, 9'h000, 9'h077,
    9'h15A, 9'h000, 9'h004, 9'h000, 9'h000,
    9'h15A, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
    9'h15A, 9'h000, 9'h003, 9'h000, 9'h001, 9'h1FF, 9'h000, 9'h000
  };

  spi_command_frame_parser i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .transfer_start_i (transfer_start_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .matched_entry_o  (matched_entry_o),
    .frame_begin_o    (frame_begin_o),
    .param_begin_o    (param_begin_o),
    .param_number_o   (param_number_o),
    .param_size_o     (param_size_o),
    .byte_offset_o    (byte_offset_o),
    .payload_byte_o   (payload_byte_o),
    .payload_valid_o  (payload_valid_o),
    .param_finish_o   (param_finish_o),
    .frame_finish_o   (frame_finish_o),
    .body_length_o    (body_length_o),
    .error_code_o     (error_code_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    result_t seen;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      board.note_byte(rx_byte_i, transfer_start_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{matched_entry: matched_entry_o, frame_begin: frame_begin_o,
               param_begin: param_begin_o, param_number: param_number_o,
               param_size: param_size_o, byte_offset: byte_offset_o,
               payload_byte: payload_byte_o, payload_valid: payload_valid_o,
               param_finish: param_finish_o, frame_finish: frame_finish_o,
               body_length: body_length_o, error_code: err_e'(error_code_o)};
      board.check_result(seen);
    end
  end

  initial begin : receiver
    int unsigned n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        n = hold_req;
        hold_req = 0;
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    transfer_start_i <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_table();
    for (int i = 0; i < NumEntries; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= IndexWidth'(i);
      cfg_data_i <= cmd_words[i];
      board.set_entry(i, cmd_words[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [EntryWidth-1:0] pick_entry(int unsigned ph, int unsigned idx);
    logic [3:0] cnt;
    if (ph == 1) return 13'h1FFF;
    if (ph == 3 && idx == 0) return 13'h1000;
    if (ph == 3 && idx == 1) return 13'h0000;
    cnt = ($urandom_range(3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
    return {($urandom_range(99) < 85), 8'($urandom_range(255)), cnt};
  endfunction

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
  endtask

  task automatic send_frame();
    int          lens [17];
    int          nparams;
    int          body;
    int          split_at;
    int          flaw;
    int          idx;
    logic [7:0]  code;
    logic [12:0] ent;
    ent = board.entry[$urandom_range(NumEntries - 1)];
    code = ent[11:4];
    flaw = $urandom_range(19);
    nparams = (ent[3:0] == 0) ? 1 : $urandom_range(1, ent[3:0]);
    if (flaw == 14 && nparams < 16) nparams++;
    body = 0;
    for (int k = 0; k < nparams; k++) begin
      lens[k] = ($urandom_range(9) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
    end
    if (flaw == 15) lens[$urandom_range(nparams - 1)] = 0;
    for (int k = 0; k < nparams; k++) body += lens[k] + 2;
    if (flaw == 16) body -= $urandom_range(1, 3);
    if (flaw == 17) body += $urandom_range(1, 3);
    if (flaw == 18) code = 8'($urandom_range(255));
    if (flaw == 19) begin
      body = 0;
      nparams = 0;
    end
    split_at = -1;
    if (body > 0 && $urandom_range(5) == 0) begin
      split_at = $urandom_range(1) ? body - 1 : $urandom_range(0, body - 1);
    end
    send_byte(code, 1'b1);
    send_byte(8'(body >> 8), 1'b0);
    send_byte(8'(body), 1'b0);
    idx = 0;
    for (int k = 0; k < nparams; k++) begin
      send_byte(8'(lens[k] >> 8), idx == split_at);
      idx++;
      send_byte(8'(lens[k]), idx == split_at);
      idx++;
      for (int j = 0; j < lens[k]; j++) begin
        send_byte(8'($urandom_range(255)), idx == split_at);
        idx++;
      end
    end
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i = '0;
    transfer_start_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 32;
    recv_stall_pct = 53;
    cmd_words[0] = {1'b1, 8'h00, 4'd1};
    cmd_words[1] = {1'b1, 8'hFF, 4'd15};
    cmd_words[2] = {1'b1, 8'h5A, 4'd8};
    cmd_words[3] = {1'b0, 8'h33, 4'd3};
    write_table();
    foreach (DirectedBytes[k]) send_byte(DirectedBytes[k][7:0], DirectedBytes[k][8]);
    drain();

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      send_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 53 : 0;
      recv_stall_pct = (ph < 2) ? 53 : (ph < 4) ? 32 : 0;
      for (int unsigned i = 0; i < NumEntries; i++) cmd_words[i] = pick_entry(ph, i);
      write_table();
      if (ph == 4) hold_req = HoldCycles;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < ItemsPerPhase) begin
        if ($urandom_range(9) == 0) send_noise();
        else send_frame();
      end
      drain();
    end

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/scfp_pkg.sv
src/scfp_cmd_table.sv
src/scfp_parser.sv
src/spi_command_frame_parser.sv
bench/tb.sv
